### rtl/dls_pkg.sv
// Shared types, codes and character tables of the lexical scanner.
`default_nettype none

package dls_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 255;

  // Result queue between the scanner step and the output port.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [4:0] {
    ST_START  = 5'd0,
    ST_WORD   = 5'd1,
    ST_NUMBER = 5'd2,
    ST_GT     = 5'd3,
    ST_LT     = 5'd4,
    ST_EQ     = 5'd5,
    ST_COMMA  = 5'd6,
    ST_SEMI   = 5'd9,
    ST_COLON  = 5'd10,
    ST_PLUS   = 5'd11,
    ST_MINUS  = 5'd12,
    ST_STAR   = 5'd13,
    ST_SLASH  = 5'd14,
    ST_LPAREN = 5'd15,
    ST_RPAREN = 5'd16,
    ST_GE     = 5'd17,
    ST_NE     = 5'd18,
    ST_LE     = 5'd19,
    ST_ASSIGN = 5'd20
  } state_t;

  typedef enum logic [4:0] {
    CL_LETTER, CL_DIGIT, CL_GT, CL_LT, CL_EQ, CL_COMMA, CL_QUOTE, CL_LBRACE,
    CL_RBRACE, CL_SEMI, CL_COLON, CL_PLUS, CL_MINUS, CL_STAR, CL_SLASH,
    CL_LPAREN, CL_RPAREN, CL_BLANK, CL_BAD
  } class_t;

  typedef enum logic [2:0] {
    KIND_WORD   = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_STRING = 3'd2,
    KIND_SYMBOL = 3'd3,
    KIND_END    = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_BAD_CHAR     = 3'd1,
    ERR_DIGIT_LETTER = 3'd2,
    ERR_STRAY_BRACE  = 3'd3,
    ERR_BAD_COLON    = 3'd4,
    ERR_UNTERMINATED = 3'd5
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  sym;
    logic [7:0]  len;
    logic [15:0] line;
    err_t        err;
    logic        last;
  } result_t;

  typedef struct packed {
    state_t      scan;
    logic        in_comment;
    logic        in_string;
    logic [7:0]  count;
    logic [15:0] line;
    logic        line_start;
    logic        halted;
  } scan_regs_t;

  function automatic class_t char_class(input logic [7:0] ch);
    class_t c;
    case (ch)
      8'h3E: c = CL_GT;      // >
      8'h3C: c = CL_LT;      // <
      8'h3D: c = CL_EQ;      // =
      8'h2C: c = CL_COMMA;   // ,
      8'h27: c = CL_QUOTE;   // single quote
      8'h7B: c = CL_LBRACE;  // {
      8'h7D: c = CL_RBRACE;  // }
      8'h3B: c = CL_SEMI;    // ;
      8'h3A: c = CL_COLON;   // :
      8'h2B: c = CL_PLUS;
      8'h2D: c = CL_MINUS;
      8'h2A: c = CL_STAR;
      8'h2F: c = CL_SLASH;
      8'h28: c = CL_LPAREN;
      8'h29: c = CL_RPAREN;
      8'h20, 8'h09: c = CL_BLANK;
      default: begin
        if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) begin
          c = CL_LETTER;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
          c = CL_DIGIT;
        end else begin
          c = CL_BAD;
        end
      end
    endcase
    return c;
  endfunction

  // State entered from the start state by a character that opens a token.
  function automatic state_t start_state(input class_t c);
    state_t s;
    case (c)
      CL_LETTER: s = ST_WORD;
      CL_DIGIT:  s = ST_NUMBER;
      CL_GT:     s = ST_GT;
      CL_LT:     s = ST_LT;
      CL_EQ:     s = ST_EQ;
      CL_COMMA:  s = ST_COMMA;
      CL_SEMI:   s = ST_SEMI;
      CL_COLON:  s = ST_COLON;
      CL_PLUS:   s = ST_PLUS;
      CL_MINUS:  s = ST_MINUS;
      CL_STAR:   s = ST_STAR;
      CL_SLASH:  s = ST_SLASH;
      CL_LPAREN: s = ST_LPAREN;
      CL_RPAREN: s = ST_RPAREN;
      default:   s = ST_START;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] symbol_of(input state_t s);
    logic [3:0] code;
    case (s)
      ST_GT:     code = 4'd0;
      ST_LT:     code = 4'd1;
      ST_EQ:     code = 4'd2;
      ST_COMMA:  code = 4'd3;
      ST_SEMI:   code = 4'd4;
      ST_COLON:  code = 4'd5;
      ST_PLUS:   code = 4'd6;
      ST_MINUS:  code = 4'd7;
      ST_STAR:   code = 4'd8;
      ST_SLASH:  code = 4'd9;
      ST_LPAREN: code = 4'd10;
      ST_RPAREN: code = 4'd11;
      ST_GE:     code = 4'd12;
      ST_NE:     code = 4'd13;
      ST_LE:     code = 4'd14;
      ST_ASSIGN: code = 4'd15;
      default:   code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### rtl/dls_step.sv
// Next-state and result logic of the scanner for one source byte or end of input.
`default_nettype none

module dls_step #(
  parameter int unsigned MAX_TOKEN_LEN = dls_pkg::MAX_TOKEN_LEN_DEF
) (
  input  dls_pkg::scan_regs_t cur,
  input  logic                op,
  input  logic [7:0]          ch,
  output dls_pkg::scan_regs_t nxt,
  output logic                v0,
  output logic                v1,
  output dls_pkg::result_t    r0,
  output dls_pkg::result_t    r1
);

  localparam logic [7:0] LEN_CAP = (MAX_TOKEN_LEN > 255) ? 8'd255 : 8'(MAX_TOKEN_LEN);

  dls_pkg::class_t  cls;
  dls_pkg::state_t  nx;
  dls_pkg::err_t    nx_err;
  logic             cont;
  logic [15:0]      line;
  logic [7:0]       bumped;
  dls_pkg::result_t pend;
  dls_pkg::result_t fail_r;

  assign cls    = dls_pkg::char_class(ch);
  assign bumped = (cur.count < LEN_CAP) ? cur.count + 8'd1 : cur.count;

  // Transition out of a token that is already open.
  always_comb begin
    cont   = 1'b0;
    nx     = dls_pkg::ST_START;
    nx_err = dls_pkg::ERR_NONE;
    case (cur.scan)
      dls_pkg::ST_WORD: begin
        if (cls == dls_pkg::CL_LETTER || cls == dls_pkg::CL_DIGIT) begin
          cont = 1'b1;
          nx   = dls_pkg::ST_WORD;
        end
      end
      dls_pkg::ST_NUMBER: begin
        if (cls == dls_pkg::CL_LETTER) begin
          nx_err = dls_pkg::ERR_DIGIT_LETTER;
        end else if (cls == dls_pkg::CL_DIGIT) begin
          cont = 1'b1;
          nx   = dls_pkg::ST_NUMBER;
        end
      end
      dls_pkg::ST_GT: begin
        if (cls == dls_pkg::CL_EQ) begin
          cont = 1'b1;
          nx   = dls_pkg::ST_GE;
        end
      end
      dls_pkg::ST_LT: begin
        if (cls == dls_pkg::CL_GT) begin
          cont = 1'b1;
          nx   = dls_pkg::ST_NE;
        end else if (cls == dls_pkg::CL_EQ) begin
          cont = 1'b1;
          nx   = dls_pkg::ST_LE;
        end
      end
      dls_pkg::ST_COLON: begin
        // A colon may only be followed by '=' or a separator.
        if (cls == dls_pkg::CL_EQ) begin
          cont = 1'b1;
          nx   = dls_pkg::ST_ASSIGN;
        end else if (cls != dls_pkg::CL_BLANK) begin
          nx_err = dls_pkg::ERR_BAD_COLON;
        end
      end
      default: begin
        cont = 1'b0;
      end
    endcase
  end

  always_comb begin
    nxt  = cur;
    v0   = 1'b0;
    v1   = 1'b0;
    r0   = '0;
    r1   = '0;
    line = cur.line;
    if (op == dls_pkg::OP_BYTE && cur.line_start) begin
      line = cur.line + 16'd1;
    end

    pend.kind = (cur.scan == dls_pkg::ST_WORD)   ? dls_pkg::KIND_WORD :
                (cur.scan == dls_pkg::ST_NUMBER) ? dls_pkg::KIND_NUMBER :
                                                   dls_pkg::KIND_SYMBOL;
    pend.sym  = dls_pkg::symbol_of(cur.scan);
    pend.len  = cur.count;
    pend.line = line;
    pend.err  = dls_pkg::ERR_NONE;
    pend.last = 1'b0;

    fail_r      = '0;
    fail_r.kind = dls_pkg::KIND_ERROR;
    fail_r.line = line;

    if (!cur.halted) begin
      if (op == dls_pkg::OP_END) begin
        if (cur.in_string || cur.in_comment) begin
          v0          = 1'b1;
          r0          = fail_r;
          r0.err      = dls_pkg::ERR_UNTERMINATED;
          nxt.halted  = 1'b1;
        end else if (cur.scan != dls_pkg::ST_START) begin
          v0      = 1'b1;
          r0      = pend;
          v1      = 1'b1;
          r1.kind = dls_pkg::KIND_END;
          r1.line = line;
        end else begin
          v0      = 1'b1;
          r0.kind = dls_pkg::KIND_END;
          r0.line = line;
        end
        nxt.scan       = dls_pkg::ST_START;
        nxt.count      = 8'd0;
        nxt.in_string  = 1'b0;
        nxt.in_comment = 1'b0;
        nxt.line_start = 1'b1;
      end else begin
        nxt.line       = line;
        nxt.line_start = (ch == dls_pkg::CH_LF);
        if (ch == dls_pkg::CH_LF) begin
          if (cur.in_string) begin
            v0         = 1'b1;
            r0         = fail_r;
            r0.err     = dls_pkg::ERR_UNTERMINATED;
            nxt.halted = 1'b1;
          end else if (!cur.in_comment && cur.scan != dls_pkg::ST_START) begin
            v0        = 1'b1;
            r0        = pend;
            nxt.scan  = dls_pkg::ST_START;
            nxt.count = 8'd0;
          end
        end else if (cur.in_string) begin
          if (cls == dls_pkg::CL_QUOTE) begin
            v0            = 1'b1;
            r0.kind       = dls_pkg::KIND_STRING;
            r0.len        = cur.count;
            r0.line       = line;
            nxt.in_string = 1'b0;
            nxt.count     = 8'd0;
          end else begin
            nxt.count = bumped;
          end
        end else if (cur.in_comment) begin
          if (cls == dls_pkg::CL_RBRACE) begin
            nxt.in_comment = 1'b0;
          end
        end else if (cls == dls_pkg::CL_BAD) begin
          v0         = 1'b1;
          r0         = fail_r;
          r0.err     = dls_pkg::ERR_BAD_CHAR;
          nxt.halted = 1'b1;
        end else if (cur.scan != dls_pkg::ST_START && cont) begin
          nxt.scan  = nx;
          nxt.count = bumped;
        end else if (cur.scan != dls_pkg::ST_START && nx_err != dls_pkg::ERR_NONE) begin
          v0         = 1'b1;
          r0         = fail_r;
          r0.err     = nx_err;
          nxt.halted = 1'b1;
        end else begin
          // The open token ends here; the byte then starts from the start state.
          if (cur.scan != dls_pkg::ST_START) begin
            v0        = 1'b1;
            r0        = pend;
            nxt.scan  = dls_pkg::ST_START;
            nxt.count = 8'd0;
          end
          case (cls)
            dls_pkg::CL_QUOTE: begin
              nxt.in_string = 1'b1;
              nxt.count     = 8'd0;
            end
            dls_pkg::CL_LBRACE: begin
              nxt.in_comment = 1'b1;
            end
            dls_pkg::CL_RBRACE: begin
              nxt.halted = 1'b1;
              if (v0) begin
                v1     = 1'b1;
                r1     = fail_r;
                r1.err = dls_pkg::ERR_STRAY_BRACE;
              end else begin
                v0     = 1'b1;
                r0     = fail_r;
                r0.err = dls_pkg::ERR_STRAY_BRACE;
              end
            end
            dls_pkg::CL_BLANK: begin
              nxt.scan = dls_pkg::ST_START;
            end
            default: begin
              nxt.scan  = dls_pkg::start_state(cls);
              nxt.count = 8'd1;
            end
          endcase
        end
      end
    end

    if (v1) begin
      r1.last = 1'b1;
    end else if (v0) begin
      r0.last = 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/dls_queue.sv
// Result queue: takes up to two results per cycle and hands out one per transaction.
`default_nettype none

module dls_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push0,
  input  logic             push1,
  input  dls_pkg::result_t din0,
  input  dls_pkg::result_t din1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output dls_pkg::result_t dout
);

  localparam int unsigned PTR_W = dls_pkg::QUEUE_PTR_W;
  localparam int unsigned CNT_W = dls_pkg::QUEUE_CNT_W;

  dls_pkg::result_t entries [dls_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && out_ready;
  assign dout      = entries[rd_ptr];
  // Room for the two results that one item may cause.
  assign room      = (cnt <= CNT_W'(dls_pkg::QUEUE_DEPTH - 2));
  assign cnt_next  = cnt + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push1) begin
        wr_ptr <= wr_ptr + PTR_W'(2);
      end else if (push0) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= din0;
    end
    if (push1) begin
      entries[wr_ptr + PTR_W'(1)] <= din1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(dls_pkg::QUEUE_DEPTH))
    else $error("result queue holds more entries than its depth");

endmodule

`default_nettype wire

### rtl/dfa_lexical_scanner.sv
// Top level of the table-driven lexical scanner with streaming ports.
//
//  channel  | direction | tdata                         | tuser       | tlast
//  s_axis   | in        | ch                            | op          | -
//  m_axis   | out       | symbol_code, length, line,err | token_kind  | last_of_run
//
// One source byte is taken per cycle while the queue has room; its scan step is one
// level of logic from the scanner registers into the result queue, which registers
// each result before it leaves. An item can cause two results; the output drains one
// per cycle while m_axis_tready is high, so the four-entry result queue sets the rate
// when the output stalls: input is taken while the queue has room for two results.
// Reset is synchronous and clears the scanner state and the queue at once. After an
// error the block drops every input without a result until reset.
`default_nettype none

module dfa_lexical_scanner #(
  parameter int unsigned MAX_TOKEN_LEN = dls_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [3:0] symbol_code, [11:4] token_length,
                                      // [27:12] line_number, [30:28] error_code, [31] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
  output logic        m_axis_tlast    // last_of_run
);

  dls_pkg::scan_regs_t regs;
  dls_pkg::scan_regs_t regs_next;
  dls_pkg::result_t    r0;
  dls_pkg::result_t    r1;
  dls_pkg::result_t    head;
  logic                v0;
  logic                v1;
  logic                accept;
  logic                room;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dls_step #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_step (
    .cur (regs),
    .op  (s_axis_tuser),
    .ch  (s_axis_tdata),
    .nxt (regs_next),
    .v0  (v0),
    .v1  (v1),
    .r0  (r0),
    .r1  (r1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.scan       <= dls_pkg::ST_START;
      regs.in_comment <= 1'b0;
      regs.in_string  <= 1'b0;
      regs.count      <= 8'd0;
      regs.line       <= 16'd0;
      regs.line_start <= 1'b1;
      regs.halted     <= 1'b0;
    end else if (accept) begin
      regs <= regs_next;
    end
  end

  dls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (accept && v0),
    .push1     (accept && v1),
    .din0      (r0),
    .din1      (r1),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .dout      (head)
  );

  assign m_axis_tdata = {1'b0, head.err, head.line, head.len, head.sym};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && regs.halted) |-> !v0 && !v1)
    else $error("result produced after an error");

  a_end_resets_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && !regs.halted && s_axis_tuser == dls_pkg::OP_END)
      |=> (regs.scan == dls_pkg::ST_START && regs.line_start && regs.count == 8'd0))
    else $error("end of input did not return the scanner to its start state");

  a_line_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && !regs.halted && s_axis_tuser == dls_pkg::OP_BYTE && regs.line_start)
      |=> regs.line == 16'($past(regs.line) + 16'd1))
    else $error("line counter did not advance on the first byte of a line");

  a_second_slot: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (v0 && r1.last && !r0.last))
    else $error("second result without a first or with a wrong last mark");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the lexical scanner: token prediction, stream stimulus, stalls.
`timescale 1ns / 1ps

module tb;
  import dls_pkg::*;

  localparam int LEN_CAP = (MAX_TOKEN_LEN_DEF > 255) ? 255 : MAX_TOKEN_LEN_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS = 60;
  localparam int HOLD_AT = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [3:0] NO_SYMBOL = 4'd0;

  typedef enum logic [3:0] {
    SYM_GT, SYM_LT, SYM_EQ, SYM_COMMA, SYM_SEMI, SYM_COLON, SYM_PLUS, SYM_MINUS,
    SYM_STAR, SYM_SLASH, SYM_LPAREN, SYM_RPAREN, SYM_GE, SYM_NE, SYM_LE, SYM_ASSIGN
  } sym_t;

  typedef enum int {
    GEN_WORD, GEN_NUMBER, GEN_STRING, GEN_SYMBOL, GEN_COMMENT, GEN_END
  } gen_t;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } src_item_t;

  class token_scoreboard;
    state_t      scan;
    bit          in_comment;
    bit          in_string;
    bit          halted;
    bit          line_start;
    logic [7:0]  count;
    logic [15:0] line;
    result_t     token_q[$];
    result_t     step_r[2];
    int          step_n;
    int          fail_count;

    function new();
      scan = ST_START;
      in_comment = 1'b0;
      in_string = 1'b0;
      halted = 1'b0;
      line_start = 1'b1;
      count = 8'd0;
      line = 16'd0;
      fail_count = 0;
    endfunction

    function class_t classify(logic [7:0] c);
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CL_LETTER;
      if (c >= "0" && c <= "9") return CL_DIGIT;
      case (c)
        ">": return CL_GT;
        "<": return CL_LT;
        "=": return CL_EQ;
        ",": return CL_COMMA;
        "'": return CL_QUOTE;
        "{": return CL_LBRACE;
        "}": return CL_RBRACE;
        ";": return CL_SEMI;
        ":": return CL_COLON;
        "+": return CL_PLUS;
        "-": return CL_MINUS;
        "*": return CL_STAR;
        "/": return CL_SLASH;
        "(": return CL_LPAREN;
        ")": return CL_RPAREN;
        " ", CH_TAB: return CL_BLANK;
        default: return CL_BAD;
      endcase
    endfunction

    function logic [3:0] sym_code(state_t s);
      case (s)
        ST_GT:     return SYM_GT;
        ST_LT:     return SYM_LT;
        ST_EQ:     return SYM_EQ;
        ST_COMMA:  return SYM_COMMA;
        ST_SEMI:   return SYM_SEMI;
        ST_COLON:  return SYM_COLON;
        ST_PLUS:   return SYM_PLUS;
        ST_MINUS:  return SYM_MINUS;
        ST_STAR:   return SYM_STAR;
        ST_SLASH:  return SYM_SLASH;
        ST_LPAREN: return SYM_LPAREN;
        ST_RPAREN: return SYM_RPAREN;
        ST_GE:     return SYM_GE;
        ST_NE:     return SYM_NE;
        ST_LE:     return SYM_LE;
        ST_ASSIGN: return SYM_ASSIGN;
        default:   return NO_SYMBOL;
      endcase
    endfunction

    // Decides what a character does to the token in progress: extend it, close it, or fail.
    function void advance(state_t s, class_t k, output state_t nx, output err_t e,
                          output bit ends);
      nx = s;
      e = ERR_NONE;
      ends = 1'b0;
      case (s)
        ST_WORD: ends = !(k == CL_LETTER || k == CL_DIGIT);
        ST_NUMBER: begin
          if (k == CL_LETTER) e = ERR_DIGIT_LETTER;
          else ends = (k != CL_DIGIT);
        end
        ST_GT: begin
          if (k == CL_EQ) nx = ST_GE;
          else ends = 1'b1;
        end
        ST_LT: begin
          if (k == CL_GT) nx = ST_NE;
          else if (k == CL_EQ) nx = ST_LE;
          else ends = 1'b1;
        end
        ST_COLON: begin
          if (k == CL_EQ) nx = ST_ASSIGN;
          else if (k == CL_BLANK) ends = 1'b1;
          else e = ERR_BAD_COLON;
        end
        default: ends = 1'b1;
      endcase
    endfunction

    function void push(kind_t kind, logic [3:0] sym, logic [7:0] len, err_t err);
      step_r[step_n].kind = kind;
      step_r[step_n].sym = sym;
      step_r[step_n].len = len;
      step_r[step_n].line = line;
      step_r[step_n].err = err;
      step_r[step_n].last = 1'b0;
      step_n++;
    endfunction

    function void fail(err_t code);
      push(KIND_ERROR, NO_SYMBOL, 8'd0, code);
      halted = 1'b1;
    endfunction

    function void bump();
      if (count < LEN_CAP) count++;
    endfunction

    function void emit_pending();
      case (scan)
        ST_WORD:   push(KIND_WORD, NO_SYMBOL, count, ERR_NONE);
        ST_NUMBER: push(KIND_NUMBER, NO_SYMBOL, count, ERR_NONE);
        default:   push(KIND_SYMBOL, sym_code(scan), count, ERR_NONE);
      endcase
      scan = ST_START;
      count = 8'd0;
    endfunction

    // Runs one accepted input transaction and queues the tokens it produces.
    function void note_byte(logic op, logic [7:0] ch);
      class_t k;
      state_t nx;
      err_t   e;
      bit     ends;
      step_n = 0;
      if (halted) return;
      if (op == OP_END) begin
        if (in_string || in_comment) begin
          fail(ERR_UNTERMINATED);
        end else begin
          if (scan != ST_START) emit_pending();
          push(KIND_END, NO_SYMBOL, 8'd0, ERR_NONE);
        end
        scan = ST_START;
        count = 8'd0;
        in_string = 1'b0;
        in_comment = 1'b0;
        line_start = 1'b1;
      end else begin
        if (line_start) begin
          line = line + 16'd1;
          line_start = 1'b0;
        end
        if (ch == CH_LF) begin
          line_start = 1'b1;
          if (in_string) fail(ERR_UNTERMINATED);
          else if (!in_comment && scan != ST_START) emit_pending();
        end else if (in_string) begin
          if (ch == "'") begin
            push(KIND_STRING, NO_SYMBOL, count, ERR_NONE);
            in_string = 1'b0;
            count = 8'd0;
          end else begin
            bump();
          end
        end else if (in_comment) begin
          if (ch == "}") in_comment = 1'b0;
        end else begin
          k = classify(ch);
          if (k == CL_BAD) begin
            fail(ERR_BAD_CHAR);
          end else begin
            ends = 1'b1;
            if (scan != ST_START) begin
              advance(scan, k, nx, e, ends);
              if (e != ERR_NONE) begin
                fail(e);
              end else if (!ends) begin
                scan = nx;
                bump();
              end else begin
                emit_pending();
              end
            end
            if (!halted && ends) begin
              nx = ST_START;
              case (k)
                CL_QUOTE: begin
                  in_string = 1'b1;
                  count = 8'd0;
                end
                CL_LBRACE: in_comment = 1'b1;
                CL_RBRACE: fail(ERR_STRAY_BRACE);
                CL_LETTER: nx = ST_WORD;
                CL_DIGIT:  nx = ST_NUMBER;
                CL_GT:     nx = ST_GT;
                CL_LT:     nx = ST_LT;
                CL_EQ:     nx = ST_EQ;
                CL_COMMA:  nx = ST_COMMA;
                CL_SEMI:   nx = ST_SEMI;
                CL_COLON:  nx = ST_COLON;
                CL_PLUS:   nx = ST_PLUS;
                CL_MINUS:  nx = ST_MINUS;
                CL_STAR:   nx = ST_STAR;
                CL_SLASH:  nx = ST_SLASH;
                CL_LPAREN: nx = ST_LPAREN;
                CL_RPAREN: nx = ST_RPAREN;
                default: ;
              endcase
              if (nx != ST_START) begin
                scan = nx;
                count = 8'd1;
              end
            end
          end
        end
      end
      if (step_n > 0) step_r[step_n - 1].last = 1'b1;
      for (int j = 0; j < step_n; j++) token_q.push_back(step_r[j]);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_token(logic [2:0] kind, logic [3:0] sym, logic [7:0] len,
                              logic [15:0] line_no, logic [2:0] err, logic last, logic pad);
      result_t want;
      if (token_q.size() == 0) begin
        $error("unexpected result: token_kind %0d line_number %0d", kind, line_no);
        fail_count++;
        return;
      end
      want = token_q.pop_front();
      compare("token_kind", want.kind, kind);
      compare("symbol_code", want.sym, sym);
      compare("token_length", want.len, len);
      compare("line_number", want.line, line_no);
      compare("error_code", want.err, err);
      compare("last_of_run", want.last, last);
      compare("tdata_pad", 1'b0, pad);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  token_scoreboard sb;
  src_item_t       src_q[$];
  bit              hold_req = 1'b0;
  bit              hold_done = 1'b0;
  bit              quiet_tail = 1'b0;
  bit              src_done = 1'b0;

  string sym_text [16] = '{">", "<", "=", ",", ";", ":", "+", "-", "*", "/", "(", ")",
                           ">=", "<>", "<=", ":="};

  dfa_lexical_scanner dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic void put_byte(logic [7:0] c);
    src_item_t it;
    it.op = OP_BYTE;
    it.ch = c;
    src_q.push_back(it);
  endfunction

  // The byte of an end-of-input transaction is ignored, so it is random.
  function automatic void put_end();
    src_item_t it;
    it.op = OP_END;
    it.ch = 8'($urandom_range(0, 255));
    src_q.push_back(it);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? "A" + c : "a" + c;
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 2) == 0) return "0" + 8'($urandom_range(0, 9));
    return rand_letter();
  endfunction

  function automatic logic [7:0] rand_byte_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
    return c;
  endfunction

  function automatic void put_token(gen_t g, int len, int sym);
    case (g)
      GEN_WORD: begin
        put_byte(rand_letter());
        repeat (len - 1) put_byte(rand_alnum());
      end
      GEN_NUMBER: repeat (len) put_byte("0" + 8'($urandom_range(0, 9)));
      GEN_STRING: begin
        put_byte("'");
        repeat (len) put_byte(rand_byte_except("'", CH_LF));
        put_byte("'");
      end
      GEN_SYMBOL: put_text(sym_text[sym]);
      GEN_COMMENT: begin
        put_byte("{");
        repeat (len) put_byte(rand_byte_except("}", "}"));
        put_byte("}");
      end
      default: put_end();
    endcase
  endfunction

  // Well-formed text with random content; one token is long enough to saturate the length.
  function automatic void gen_stream(int items);
    gen_t g;
    gen_t prev;
    bit   prev_colon;
    int   long_at;
    int   target;
    int   len;
    int   sym;
    int   r;
    prev = GEN_END;
    prev_colon = 1'b0;
    long_at = src_q.size() + $urandom_range(0, items / 2);
    target = src_q.size() + items;
    while (src_q.size() < target) begin
      if (long_at >= 0 && src_q.size() >= long_at) begin
        g = gen_t'($urandom_range(0, 2));
        len = $urandom_range(256, 270);
        long_at = -1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) g = GEN_WORD;
        else if (r < 42) g = GEN_NUMBER;
        else if (r < 55) g = GEN_STRING;
        else if (r < 85) g = GEN_SYMBOL;
        else if (r < 95) g = GEN_COMMENT;
        else g = GEN_END;
        if (g == GEN_STRING || g == GEN_COMMENT) len = $urandom_range(0, 8);
        else len = $urandom_range(1, 8);
      end
      // A lone colon or digits followed by a letter would end the run early.
      if (prev_colon || (prev == GEN_NUMBER && g == GEN_WORD) || $urandom_range(0, 2) != 0) begin
        repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 3))
            0, 1: put_byte(" ");
            2: put_byte(CH_TAB);
            default: put_byte(CH_LF);
          endcase
        end
      end
      sym = $urandom_range(0, 15);
      put_token(g, len, sym);
      prev = g;
      prev_colon = (g == GEN_SYMBOL && sym == SYM_COLON);
    end
  endfunction

  // One of eight error cases or none, picked at random, then noise that a halted block must drop.
  function automatic void gen_failure();
    string      colon_breakers;
    logic [7:0] c;
    colon_breakers = "a0<>,;:+-*/(){}'";
    put_byte(" ");
    case ($urandom_range(0, 8))
      1: begin
        if ($urandom_range(0, 1)) put_token(GEN_WORD, 3, 0);
        case ($urandom_range(0, 3))
          0: c = 8'h00;
          1: c = 8'h0D;
          default: do c = 8'($urandom_range(0, 255));
                   while (c == CH_LF || sb.classify(c) != CL_BAD);
        endcase
        put_byte(c);
      end
      2: begin
        put_token(GEN_NUMBER, $urandom_range(1, 4), 0);
        put_byte(rand_letter());
      end
      3: begin
        if ($urandom_range(0, 1)) put_token(GEN_WORD, 2, 0);
        put_byte("}");
      end
      4: begin
        put_byte(":");
        put_byte(colon_breakers[$urandom_range(0, colon_breakers.len() - 1)]);
      end
      5: begin
        put_text("'ab");
        put_byte(CH_LF);
      end
      6: begin
        put_byte("'");
        put_byte(CH_LF);
      end
      7: begin
        put_text("'xy");
        put_end();
      end
      8: begin
        put_text("{ab");
        put_end();
      end
      default: ;
    endcase
    repeat (20) begin
      if ($urandom_range(0, 3) == 0) put_end();
      else put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin : source
    int i;
    bit idle_on;
    sb = new();
    idle_on = 1'b0;
    put_end();
    put_text("Za9 0'");
    put_byte(8'hFF);
    put_byte(8'h00);
    put_text("'{");
    put_byte(CH_LF);
    put_byte(8'h0D);
    put_text("}>=<><=:=(");
    put_end();
    gen_stream(RANDOM_ITEMS);
    gen_failure();

    @(posedge clk);
    while (rst) @(posedge clk);
    for (i = 0; i < src_q.size(); i++) begin
      if (i % 48 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i >= src_q.size() - QUIET_ITEMS) quiet_tail = 1'b1;
      if (idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tuser <= src_q[i].op;
      s_axis_tdata <= src_q[i].ch;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
    end
    s_axis_tvalid <= 1'b0;
    src_done = 1'b1;
  end

  initial begin : sink
    bit idle_on;
    int n;
    idle_on = 1'b0;
    n = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (n % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
      n++;
      if (hold_req && !hold_done) begin
        // Long hold-off so the result queue fills and the input side backs up.
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_token(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4],
                       m_axis_tdata[27:12], m_axis_tdata[30:28], m_axis_tlast,
                       m_axis_tdata[31]);
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stalled = 0;
      else
        stalled++;
    end
    $display("dfa_lexical_scanner regression: fail");
    $finish;
  end

  initial begin : finish_run
    wait (src_done);
    @(posedge clk);
    while (sb.token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("dfa_lexical_scanner regression: pass");
    end else begin
      $display("dfa_lexical_scanner regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dls_pkg.sv
rtl/dls_step.sv
rtl/dls_queue.sv
rtl/dfa_lexical_scanner.sv
tb/tb.sv
